// ===== design/adr_pkg.sv =====
// Shared types and constants for the audio downmix and resampler block.
package adr_pkg;

	localparam int unsigned SAMPLE_W         = 16;
	localparam int unsigned RATE_W           = 18;
	localparam int unsigned CHAN_W           = 4;
	localparam int unsigned BLOCK_W          = 13;
	localparam int unsigned SRC_IDX_W        = 12;
	localparam int unsigned PHASE_W          = 18;
	localparam int unsigned PHASE_WORK_W     = 19;
	localparam int unsigned OUTPUT_RATE      = 48000;
	localparam int unsigned MAX_BLOCK_FRAMES = 4096;
	localparam int unsigned MAX_RESULTS      = 7;
	localparam int unsigned RUN_CNT_W        = 3;
	localparam int unsigned CFG_IDX_W        = 2;
	localparam int unsigned CFG_DATA_W       = 18;
	localparam int unsigned QDEPTH           = 4;
	localparam int unsigned QPTR_W           = 2;
	localparam int unsigned QCNT_W           = 3;

	// floor(a*707/1000) == (a*MUL_C) >> MUL_SHIFT for every a up to 32768
	localparam int unsigned MUL_C     = 47445967;
	localparam int unsigned MUL_C_W   = 26;
	localparam int unsigned MUL_SHIFT = 26;
	localparam int unsigned MAG_W     = 17;

	localparam int unsigned RST_SOURCE_RATE   = 48000;
	localparam int unsigned RST_CHANNEL_COUNT = 2;
	localparam int unsigned RST_BLOCK_FRAMES  = 1024;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample_0;
		sample_t sample_1;
		sample_t sample_2;
		sample_t sample_3;
		sample_t sample_4;
		sample_t sample_5;
	} in_word_t;

	typedef struct packed {
		sample_t out_left;
		sample_t out_right;
		logic    last_of_run;
		logic    block_end;
	} out_word_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    last_frame;
	} mix_word_t;

	typedef enum logic [1:0] {
		MIX_MONO,
		MIX_STEREO,
		MIX_QUAD,
		MIX_SIX
	} mix_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_RATE   = 2'd0,
		CFG_CHANNEL_COUNT = 2'd1,
		CFG_BLOCK_FRAMES  = 2'd2
	} cfg_reg_t;

endpackage

// ===== design/adr_in_if.sv =====
// Source frame channel: valid/ready handshake with six samples.
interface adr_in_if;
	logic             valid;
	logic             ready;
	adr_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/adr_out_if.sv =====
// Stereo result channel: valid/ready handshake with the stereo word.
interface adr_out_if;
	logic               valid;
	logic               ready;
	adr_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/adr_front.sv =====
// Front end: accepts source frames, tracks block position, downmixes to stereo.
module adr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [adr_pkg::RATE_W-1:0]      source_rate,
	input  logic [adr_pkg::CHAN_W-1:0]      channel_count,
	input  logic [adr_pkg::BLOCK_W-1:0]     block_frames,
	adr_in_if.sink                          frame,
	output logic                            push_valid,
	input  logic                            push_ready,
	output adr_pkg::mix_word_t              push_word
);

	localparam int unsigned PROD_W = adr_pkg::MAG_W + adr_pkg::MUL_C_W;
	localparam int unsigned SUM_W  = adr_pkg::SAMPLE_W + 3;

	function automatic adr_pkg::mix_mode_t decode_mode(input logic [adr_pkg::CHAN_W-1:0] cc);
		adr_pkg::mix_mode_t m;
		if (cc >= adr_pkg::CHAN_W'(6))
			m = adr_pkg::MIX_SIX;
		else if (cc >= adr_pkg::CHAN_W'(4))
			m = adr_pkg::MIX_QUAD;
		else if (cc >= adr_pkg::CHAN_W'(2))
			m = adr_pkg::MIX_STEREO;
		else
			m = adr_pkg::MIX_MONO;
		return m;
	endfunction

	function automatic adr_pkg::sample_t sat16(input logic signed [SUM_W-1:0] x);
		adr_pkg::sample_t r;
		if (x < -SUM_W'(32768))
			r = adr_pkg::sample_t'(-32768);
		else if (x > SUM_W'(32767))
			r = adr_pkg::sample_t'(32767);
		else
			r = adr_pkg::sample_t'(x);
		return r;
	endfunction

	logic                            en;
	logic                            ignore;
	logic                            take;
	logic                            last_frame;
	logic [adr_pkg::BLOCK_W-1:0]     bf_eff;
	logic [adr_pkg::SRC_IDX_W-1:0]   src_idx_q;

	logic                            v_s1;
	logic                            last_s1;
	adr_pkg::mix_mode_t              mode_s1;
	adr_pkg::sample_t                smp_s1 [6];

	logic                            v_s2;
	logic                            last_s2;
	adr_pkg::mix_mode_t              mode_s2;
	adr_pkg::sample_t                s0_s2;
	adr_pkg::sample_t                s1_s2;
	adr_pkg::sample_t                half3_s2;
	logic [3:0]                      neg_s2;
	logic [adr_pkg::SAMPLE_W-1:0]    q_s2 [4];

	logic [adr_pkg::MAG_W-1:0]       mag [4];
	logic [PROD_W-1:0]               prod [4];
	logic signed [adr_pkg::SAMPLE_W:0] s3_adj;
	logic signed [SUM_W-1:0]         term [4];
	logic signed [SUM_W-1:0]         lsum;
	logic signed [SUM_W-1:0]         rsum;

	// Stage 0: accept and block position
	assign en          = !v_s2 || push_ready;
	assign frame.ready = en;
	assign ignore      = (source_rate == '0) || (channel_count == '0) || (block_frames == '0);
	assign take        = frame.valid && en && !ignore;
	assign bf_eff      = (block_frames > adr_pkg::BLOCK_W'(adr_pkg::MAX_BLOCK_FRAMES)) ?
		adr_pkg::BLOCK_W'(adr_pkg::MAX_BLOCK_FRAMES) : block_frames;
	assign last_frame  = ({1'b0, src_idx_q} + adr_pkg::BLOCK_W'(1)) >= bf_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_idx_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (take)
				src_idx_q <= last_frame ? '0 : src_idx_q + adr_pkg::SRC_IDX_W'(1);
			if (en) begin
				v_s1 <= take;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1[0] <= frame.data.sample_0;
			smp_s1[1] <= frame.data.sample_1;
			smp_s1[2] <= frame.data.sample_2;
			smp_s1[3] <= frame.data.sample_3;
			smp_s1[4] <= frame.data.sample_4;
			smp_s1[5] <= frame.data.sample_5;
			mode_s1   <= decode_mode(channel_count);
			last_s1   <= last_frame;
		end
	end

	// Stage 1: magnitudes times 0.707, truncated toward zero
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i]  = smp_s1[i+2][adr_pkg::SAMPLE_W-1] ?
				(~{smp_s1[i+2][adr_pkg::SAMPLE_W-1], smp_s1[i+2]} + adr_pkg::MAG_W'(1)) :
				{smp_s1[i+2][adr_pkg::SAMPLE_W-1], smp_s1[i+2]};
			prod[i] = PROD_W'(mag[i]) * PROD_W'(adr_pkg::MUL_C);
		end
		// LFE halved toward zero: bias negatives by one before the shift
		s3_adj = {smp_s1[3][adr_pkg::SAMPLE_W-1], smp_s1[3]} +
			(adr_pkg::SAMPLE_W+1)'(smp_s1[3][adr_pkg::SAMPLE_W-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				q_s2[i]   <= prod[i][adr_pkg::MUL_SHIFT +: adr_pkg::SAMPLE_W];
				neg_s2[i] <= smp_s1[i+2][adr_pkg::SAMPLE_W-1];
			end
			s0_s2    <= smp_s1[0];
			s1_s2    <= smp_s1[1];
			half3_s2 <= s3_adj[adr_pkg::SAMPLE_W:1];
			mode_s2  <= mode_s1;
			last_s2  <= last_s1;
		end
	end

	// Stage 2: signed sums and saturation
	always_comb begin
		for (int i = 0; i < 4; i++)
			term[i] = neg_s2[i] ? -signed'(SUM_W'(q_s2[i])) : signed'(SUM_W'(q_s2[i]));
		lsum = SUM_W'(s0_s2);
		rsum = SUM_W'(s1_s2);
		unique case (mode_s2)
			adr_pkg::MIX_MONO: begin
				lsum = SUM_W'(s0_s2);
				rsum = SUM_W'(s0_s2);
			end
			adr_pkg::MIX_STEREO: begin
				lsum = SUM_W'(s0_s2);
				rsum = SUM_W'(s1_s2);
			end
			adr_pkg::MIX_QUAD: begin
				lsum = SUM_W'(s0_s2) + term[0];
				rsum = SUM_W'(s1_s2) + term[1];
			end
			adr_pkg::MIX_SIX: begin
				lsum = SUM_W'(s0_s2) + term[0] + SUM_W'(half3_s2) + term[2];
				rsum = SUM_W'(s1_s2) + term[0] + SUM_W'(half3_s2) + term[3];
			end
			default: begin
				lsum = SUM_W'(s0_s2);
				rsum = SUM_W'(s1_s2);
			end
		endcase
	end

	assign push_valid           = v_s2;
	assign push_word.left       = sat16(lsum);
	assign push_word.right      = sat16(rsum);
	assign push_word.last_frame = last_s2;

endmodule

// ===== design/adr_queue.sv =====
// Short FIFO between the front end and the output sequencer.
module adr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  adr_pkg::mix_word_t push_word,
	output logic               pop_valid,
	input  logic               pop_ready,
	output adr_pkg::mix_word_t pop_word
);

	adr_pkg::mix_word_t            mem_q [adr_pkg::QDEPTH];
	logic [adr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [adr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [adr_pkg::QCNT_W-1:0]    count_q;
	logic                          push_fire;
	logic                          pop_fire;

	assign push_ready = count_q != adr_pkg::QCNT_W'(adr_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= wr_ptr_q + adr_pkg::QPTR_W'(1);
			if (pop_fire)
				rd_ptr_q <= rd_ptr_q + adr_pkg::QPTR_W'(1);
			if (push_fire && !pop_fire)
				count_q <= count_q + adr_pkg::QCNT_W'(1);
			else if (pop_fire && !push_fire)
				count_q <= count_q - adr_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_ptr_q] <= push_word;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= adr_pkg::QCNT_W'(adr_pkg::QDEPTH))
		else $error("queue count past depth");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> count_q == $past(count_q) + adr_pkg::QCNT_W'(1))
		else $error("queue count missed a push");
`endif

endmodule

// ===== design/adr_back.sv =====
// Sample-and-hold back end: at most one stereo word per cycle, none while stalled or idle.
module adr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [adr_pkg::RATE_W-1:0]  source_rate,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  adr_pkg::mix_word_t          pop_word,
	adr_out_if.source                   stereo
);

	localparam int unsigned SUM_W = adr_pkg::PHASE_WORK_W + 1;

	logic                              busy_q;
	logic [adr_pkg::PHASE_WORK_W-1:0]  ph_w_q;
	logic [adr_pkg::RUN_CNT_W-1:0]     n_q;
	logic [adr_pkg::PHASE_W-1:0]       phase_acc_q;
	adr_pkg::mix_word_t                cur_q;
	logic                              ov_q;
	adr_pkg::out_word_t                out_q;

	logic                              below;
	logic [SUM_W-1:0]                  sum;
	logic                              want_emit;
	logic                              out_free;
	logic                              step;
	logic [adr_pkg::PHASE_WORK_W-1:0]  final_ph;
	logic                              done;
	logic [adr_pkg::PHASE_W-1:0]       new_acc;
	logic                              last_run;
	logic                              pop_fire;

	assign below     = ph_w_q < adr_pkg::PHASE_WORK_W'(adr_pkg::OUTPUT_RATE);
	assign sum       = {1'b0, ph_w_q} + SUM_W'(source_rate);
	// past the seventh word of a frame the phase still advances, silently
	assign want_emit = busy_q && below && (n_q != adr_pkg::RUN_CNT_W'(adr_pkg::MAX_RESULTS));
	assign out_free  = !ov_q || stereo.ready;
	assign step      = busy_q && !(want_emit && !out_free);
	assign final_ph  = below ? sum[adr_pkg::PHASE_WORK_W-1:0] : ph_w_q;
	assign done      = step && (final_ph >= adr_pkg::PHASE_WORK_W'(adr_pkg::OUTPUT_RATE));
	assign new_acc   = cur_q.last_frame ? '0 :
		adr_pkg::PHASE_W'(final_ph - adr_pkg::PHASE_WORK_W'(adr_pkg::OUTPUT_RATE));
	assign last_run  = (sum >= SUM_W'(adr_pkg::OUTPUT_RATE)) ||
		(n_q == adr_pkg::RUN_CNT_W'(adr_pkg::MAX_RESULTS - 1));
	assign pop_ready = !busy_q || done;
	assign pop_fire  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ph_w_q      <= '0;
			n_q         <= '0;
			phase_acc_q <= '0;
			ov_q        <= 1'b0;
		end else begin
			if (pop_fire) begin
				busy_q <= 1'b1;
				ph_w_q <= {1'b0, done ? new_acc : phase_acc_q};
				n_q    <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (step) begin
				ph_w_q <= final_ph;
				if (want_emit)
					n_q <= n_q + adr_pkg::RUN_CNT_W'(1);
			end
			if (done)
				phase_acc_q <= new_acc;
			if (want_emit && out_free)
				ov_q <= 1'b1;
			else if (stereo.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire)
			cur_q <= pop_word;
		if (want_emit && out_free) begin
			out_q.out_left    <= cur_q.left;
			out_q.out_right   <= cur_q.right;
			out_q.last_of_run <= last_run;
			out_q.block_end   <= last_run && cur_q.last_frame;
		end
	end

	assign stereo.valid = ov_q;
	assign stereo.data  = out_q;

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_q.block_end) |-> out_q.last_of_run)
		else $error("block end word not last of its run");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(busy_q))
		else $error("word emitted while sequencer idle");

	a_block_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cur_q.last_frame) |=> phase_acc_q == '0)
		else $error("phase not cleared at block end");
`endif

endmodule

// ===== design/audio_downmix_resampler_top.sv =====
// A taken frame passes the front-end stages, the queue and the back end's frame and
// output registers before its first stereo word is valid. The sequencer emits a
// frame's words in turn, skipping any past the seventh, and pops the next as it ends.
// The front end takes one frame per cycle while the four-word queue has room.
// Reset: asynchronous, active low; registers return to their reset values,
// block position and phase clear to zero, no clearing pass.
module audio_downmix_resampler_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [adr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [adr_pkg::CFG_DATA_W-1:0]   wr_data,
	adr_in_if.sink                           frame,
	adr_out_if.source                        stereo
);

	logic [adr_pkg::RATE_W-1:0]   source_rate_q;
	logic [adr_pkg::CHAN_W-1:0]   channel_count_q;
	logic [adr_pkg::BLOCK_W-1:0]  block_frames_q;

	logic                         push_valid;
	logic                         push_ready;
	adr_pkg::mix_word_t           push_word;
	logic                         pop_valid;
	logic                         pop_ready;
	adr_pkg::mix_word_t           pop_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q   <= adr_pkg::RATE_W'(adr_pkg::RST_SOURCE_RATE);
			channel_count_q <= adr_pkg::CHAN_W'(adr_pkg::RST_CHANNEL_COUNT);
			block_frames_q  <= adr_pkg::BLOCK_W'(adr_pkg::RST_BLOCK_FRAMES);
		end else if (wr_en) begin
			unique case (adr_pkg::cfg_reg_t'(wr_index))
				adr_pkg::CFG_SOURCE_RATE:   source_rate_q   <= wr_data[adr_pkg::RATE_W-1:0];
				adr_pkg::CFG_CHANNEL_COUNT: channel_count_q <= wr_data[adr_pkg::CHAN_W-1:0];
				adr_pkg::CFG_BLOCK_FRAMES:  block_frames_q  <= wr_data[adr_pkg::BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	adr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_rate   (source_rate_q),
		.channel_count (channel_count_q),
		.block_frames  (block_frames_q),
		.frame         (frame),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_word     (push_word)
	);

	adr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	adr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_rate (source_rate_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_word    (pop_word),
		.stereo      (stereo)
	);

endmodule
